// ----- hw/rtl/pbi_pkg.sv -----
`timescale 1ns / 1ps

package pbi_pkg;

    // Field and register widths
    localparam int BYTE_W       = 8;
    localparam int WORD_W       = 16;
    localparam int ADDR_W       = 18;
    localparam int LINE_WORDS_W = 7;
    localparam int ROW_COUNT_W  = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;

    // Parameter defaults
    localparam int DEF_MAX_LINE_WORDS = 64;
    localparam int DEF_MAX_ROWS       = 1024;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WORDS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HAS_MASK   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PACKBITS   = 2'd3;

    // Register reset values
    localparam logic [LINE_WORDS_W-1:0] RST_LINE_WORDS = 7'd20;
    localparam logic [ROW_COUNT_W-1:0]  RST_ROW_COUNT  = 11'd200;

    // PackBits no-op command and plane counts
    localparam logic [BYTE_W-1:0] CMD_NOP     = 8'h80;
    localparam logic [2:0]        PLANES_BASE = 3'd4;
    localparam logic [2:0]        PLANES_MASK = 3'd5;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture the accepted byte
        logic step;   // perform one decode step on the held byte
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic want_out;   // this step produces a word
        logic step_last;  // this step completes the held byte
        logic out_free;   // output register can take a word this cycle
    } t_dp_status;

endpackage

// ----- hw/rtl/pbi_ctrl.sv -----
`timescale 1ns / 1ps

module pbi_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_byte_valid,
    output logic               o_byte_ready,
    input  pbi_pkg::t_dp_status i_status,
    output pbi_pkg::t_ctrl_cmd  o_cmd
);
    import pbi_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    assign o_byte_ready = (r_state == S_IDLE);
    assign accept       = i_byte_valid && o_byte_ready;

    // Step commands: hold off while a word cannot be placed
    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = accept;
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.step = !i_status.want_out || i_status.out_free;
                if (o_cmd.step && i_status.step_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted byte did not start a decode step");

endmodule

// ----- hw/rtl/pbi_datapath.sv -----
`timescale 1ns / 1ps

module pbi_datapath #(
    parameter int MAX_LINE_WORDS = pbi_pkg::DEF_MAX_LINE_WORDS,
    parameter int MAX_ROWS       = pbi_pkg::DEF_MAX_ROWS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pbi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pbi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [pbi_pkg::BYTE_W-1:0]     i_byte_in,
    input  pbi_pkg::t_ctrl_cmd             i_cmd,
    output pbi_pkg::t_dp_status            o_status,
    output logic                           o_word_valid,
    input  logic                           i_word_ready,
    output logic [pbi_pkg::ADDR_W-1:0]     o_word_addr,
    output logic                           o_is_mask,
    output logic [pbi_pkg::WORD_W-1:0]     o_word_data,
    output logic                           o_image_done,
    output logic                           o_last
);
    import pbi_pkg::*;

    localparam int LW_W  = $clog2(MAX_LINE_WORDS + 1);
    localparam int WIP_W = (MAX_LINE_WORDS > 1) ? $clog2(MAX_LINE_WORDS) : 1;
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int PRD_W = ROW_W + LW_W;

    localparam logic [1:0] PH_CMD = 2'd0;
    localparam logic [1:0] PH_LIT = 2'd1;
    localparam logic [1:0] PH_RUN = 2'd2;

    // Configuration registers
    logic [LINE_WORDS_W-1:0] r_line_words;
    logic [ROW_COUNT_W-1:0]  r_row_count;
    logic                    r_has_mask;
    logic                    r_pb;

    // Decode and placement state
    logic [1:0]        r_phase,   n_phase;
    logic [7:0]        r_lit,     n_lit;
    logic [7:0]        r_run,     n_run;
    logic              r_pending, n_pending;
    logic [7:0]        r_held,    n_held;
    logic [2:0]        r_plane,   n_plane;
    logic [WIP_W-1:0]  r_wip,     n_wip;
    logic [ROW_W-1:0]  r_row,     n_row;
    logic              r_finished, n_finished;
    logic              r_overflow, n_overflow;
    logic [BYTE_W-1:0] r_byte;

    // Output register
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    logic              r_out_mask;
    logic [WORD_W-1:0] r_out_data;
    logic              r_out_done;
    logic              r_out_last;

    logic [LW_W-1:0]    eff_lw;
    logic [ROW_W-1:0]   eff_rows;
    logic [LW_W-1:0]    wip_inc;
    logic [2:0]         plane_inc;
    logic [2:0]         planes;
    logic [ROW_W-1:0]   row_inc;
    logic               wip_end;
    logic               row_end;
    logic               img_end;
    logic               is_mask;
    logic [PRD_W-1:0]   prod;
    logic [PRD_W+2:0]   addr_full;
    logic [WORD_W-1:0]  word;
    logic               emit;
    logic               word_last;
    logic               step_last;
    logic [7:0]         run_rem;

    // Clamp sizes into range
    always_comb begin
        if (r_line_words == '0) begin
            eff_lw = LW_W'(1);
        end else if (32'(r_line_words) > MAX_LINE_WORDS) begin
            eff_lw = LW_W'(MAX_LINE_WORDS);
        end else begin
            eff_lw = LW_W'(r_line_words);
        end
        if (r_row_count == '0) begin
            eff_rows = ROW_W'(1);
        end else if (32'(r_row_count) > MAX_ROWS) begin
            eff_rows = ROW_W'(MAX_ROWS);
        end else begin
            eff_rows = ROW_W'(r_row_count);
        end
    end

    // Position advance and address of the word being placed
    assign planes    = r_has_mask ? PLANES_MASK : PLANES_BASE;
    assign wip_inc   = LW_W'(r_wip) + LW_W'(1);
    assign plane_inc = r_plane + 3'd1;
    assign row_inc   = r_row + ROW_W'(1);
    assign wip_end   = (wip_inc >= eff_lw);
    assign row_end   = wip_end && (plane_inc >= planes);
    assign img_end   = row_end && (row_inc >= eff_rows);
    assign is_mask   = (r_plane >= PLANES_BASE);
    assign prod      = r_row * eff_lw;

    always_comb begin
        if (is_mask) begin
            addr_full = (PRD_W+3)'(prod) + (PRD_W+3)'(r_wip);
        end else begin
            addr_full = {prod, 2'b00} + (PRD_W+3)'(r_plane)
                      + {(PRD_W+1)'(r_wip), 2'b00};
        end
    end

    // First byte of a pair in the upper half; a run pair repeats the byte
    assign word = r_pending ? {r_held, r_byte} : {r_byte, r_byte};

    // One decode step on the held byte
    always_comb begin
        n_phase    = r_phase;
        n_lit      = r_lit;
        n_run      = r_run;
        n_pending  = r_pending;
        n_held     = r_held;
        n_plane    = r_plane;
        n_wip      = r_wip;
        n_row      = r_row;
        n_finished = r_finished;
        n_overflow = r_overflow;
        emit       = 1'b0;
        word_last  = 1'b1;
        step_last  = 1'b1;
        run_rem    = r_run - (r_pending ? 8'd1 : 8'd2);

        if (!r_finished) begin
            if (!r_pb) begin
                // raw: every byte is data, discard is cancelled
                n_overflow = 1'b0;
                if (!r_pending) begin
                    n_held    = r_byte;
                    n_pending = 1'b1;
                end else begin
                    emit = 1'b1;
                end
            end else begin
                case (r_phase)
                    PH_LIT: begin
                        if (!r_overflow) begin
                            if (!r_pending) begin
                                n_held    = r_byte;
                                n_pending = 1'b1;
                            end else begin
                                emit = 1'b1;
                            end
                        end
                        if (r_lit != 8'd0) begin
                            n_lit = r_lit - 8'd1;
                        end
                        if (r_lit <= 8'd1) begin
                            n_phase = PH_CMD;
                        end
                    end
                    PH_RUN: begin
                        if (r_run == 8'd0 || r_overflow) begin
                            n_run   = 8'd0;
                            n_phase = PH_CMD;
                        end else if (!r_pending && r_run == 8'd1) begin
                            n_held    = r_byte;
                            n_pending = 1'b1;
                            n_run     = 8'd0;
                            n_phase   = PH_CMD;
                        end else begin
                            // one word per step, one or two repeats used
                            emit      = 1'b1;
                            n_run     = run_rem;
                            word_last = (run_rem < 8'd2) || row_end;
                            step_last = (run_rem == 8'd0) || row_end;
                            if ((run_rem == 8'd0) || row_end) begin
                                n_run   = 8'd0;
                                n_phase = PH_CMD;
                            end
                        end
                    end
                    default: begin
                        n_overflow = 1'b0;
                        n_phase    = PH_CMD;
                        if (r_byte < CMD_NOP) begin
                            n_lit   = r_byte + 8'd1;
                            n_phase = PH_LIT;
                        end else if (r_byte != CMD_NOP) begin
                            n_run   = 8'(9'd257 - {1'b0, r_byte});
                            n_phase = PH_RUN;
                        end
                    end
                endcase
            end
        end

        // Word placed: move to next position
        if (emit) begin
            n_pending = 1'b0;
            if (wip_end) begin
                n_wip = '0;
                if (plane_inc >= planes) begin
                    n_plane = 3'd0;
                    n_row   = row_inc;
                    if (r_pb) begin
                        n_overflow = 1'b1;
                    end
                    if (row_inc >= eff_rows) begin
                        n_finished = 1'b1;
                    end
                end else begin
                    n_plane = plane_inc;
                end
            end else begin
                n_wip = WIP_W'(wip_inc);
            end
        end
    end

    assign o_status.want_out  = emit;
    assign o_status.step_last = step_last;
    assign o_status.out_free  = !r_out_valid || i_word_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_words <= RST_LINE_WORDS;
            r_row_count  <= RST_ROW_COUNT;
            r_has_mask   <= 1'b0;
            r_pb         <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LINE_WORDS: r_line_words <= i_cfg_data[LINE_WORDS_W-1:0];
                REG_ROW_COUNT:  r_row_count  <= i_cfg_data[ROW_COUNT_W-1:0];
                REG_HAS_MASK:   r_has_mask   <= i_cfg_data[0];
                REG_PACKBITS:   r_pb         <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CMD;
            r_lit      <= 8'd0;
            r_run      <= 8'd0;
            r_pending  <= 1'b0;
            r_held     <= 8'd0;
            r_plane    <= 3'd0;
            r_wip      <= '0;
            r_row      <= '0;
            r_finished <= 1'b0;
            r_overflow <= 1'b0;
        end else if (i_cmd.step) begin
            r_phase    <= n_phase;
            r_lit      <= n_lit;
            r_run      <= n_run;
            r_pending  <= n_pending;
            r_held     <= n_held;
            r_plane    <= n_plane;
            r_wip      <= n_wip;
            r_row      <= n_row;
            r_finished <= n_finished;
            r_overflow <= n_overflow;
        end
    end

    // Held input byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_byte_in;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_word_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && emit) begin
            r_out_addr <= ADDR_W'(addr_full);
            r_out_mask <= is_mask;
            r_out_data <= word;
            r_out_done <= img_end;
            r_out_last <= word_last;
        end
    end

    assign o_word_valid = r_out_valid;
    assign o_word_addr  = r_out_addr;
    assign o_is_mask    = r_out_mask;
    assign o_word_data  = r_out_data;
    assign o_image_done = r_out_done;
    assign o_last       = r_out_last;

    a_no_word_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> !emit)
        else $error("word produced after the last row");

    a_plane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plane <= PLANES_BASE)
        else $error("plane index past the mask plane");

    a_discard_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> !r_pending)
        else $error("half word held while discarding row overflow");

endmodule

// ----- hw/rtl/packbits_bitplane_interleaver.sv -----
`timescale 1ns / 1ps
// Order: a taken byte is captured in the held-byte register and then decoded in the execute
// state; a word that a decode step completes is loaded into the output register and presented from it.
// A new byte is taken only once the last one is fully decoded; a run command's data byte is expanded
// one word per decode step, one more step when it ends on a half word; a held output stalls.
// Reset (synchronous, active low) restores the register defaults and clears state.

module packbits_bitplane_interleaver #(
    parameter int MAX_LINE_WORDS = pbi_pkg::DEF_MAX_LINE_WORDS,
    parameter int MAX_ROWS       = pbi_pkg::DEF_MAX_ROWS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pbi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pbi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_byte_valid,
    output logic                           o_byte_ready,
    input  logic [pbi_pkg::BYTE_W-1:0]     i_byte_in,
    output logic                           o_word_valid,
    input  logic                           i_word_ready,
    output logic [pbi_pkg::ADDR_W-1:0]     o_word_addr,
    output logic                           o_is_mask,
    output logic [pbi_pkg::WORD_W-1:0]     o_word_data,
    output logic                           o_image_done,
    output logic                           o_last
);
    import pbi_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // Sequencer
    pbi_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (i_byte_valid),
        .o_byte_ready (o_byte_ready),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    // Decode, placement and output register
    pbi_datapath #(
        .MAX_LINE_WORDS (MAX_LINE_WORDS),
        .MAX_ROWS       (MAX_ROWS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_byte_in    (i_byte_in),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_word_valid (o_word_valid),
        .i_word_ready (i_word_ready),
        .o_word_addr  (o_word_addr),
        .o_is_mask    (o_is_mask),
        .o_word_data  (o_word_data),
        .o_image_done (o_image_done),
        .o_last       (o_last)
    );

endmodule

// ----- tb/packbits_bitplane_interleaver_tb.sv -----
`timescale 1ns / 1ps

module packbits_bitplane_interleaver_tb;
    import pbi_pkg::*;

    // Decoder phase of the PackBits command stream
    typedef enum logic [1:0] {PH_CMD, PH_LITERAL, PH_RUN} t_dec_phase;

    // One placed word as it leaves the block
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              mask;
        logic [WORD_W-1:0] data;
        logic              done;
        logic              last;
    } t_word_rec;

    localparam int MAX_RUN_BYTES = 128;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int HOLD_OFF      = 400;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx    = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data   = '0;
    logic                   i_byte_valid = 1'b0;
    logic [BYTE_W-1:0]      i_byte_in    = '0;
    logic                   i_word_ready = 1'b0;
    logic                   o_byte_ready;
    logic                   o_word_valid;
    logic [ADDR_W-1:0]      o_word_addr;
    logic                   o_is_mask;
    logic [WORD_W-1:0]      o_word_data;
    logic                   o_image_done;
    logic                   o_last;

    packbits_bitplane_interleaver DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_byte_valid (i_byte_valid),
        .o_byte_ready (o_byte_ready),
        .i_byte_in    (i_byte_in),
        .o_word_valid (o_word_valid),
        .i_word_ready (i_word_ready),
        .o_word_addr  (o_word_addr),
        .o_is_mask    (o_is_mask),
        .o_word_data  (o_word_data),
        .o_image_done (o_image_done),
        .o_last       (o_last)
    );

    always #2 i_clk = ~i_clk;

    // Idling controls and counters
    int unsigned tx_idle_pct = 37;
    int unsigned rx_idle_pct = 48;
    int unsigned hold_cycles = 0;
    int unsigned err_count   = 0;
    int unsigned bytes_sent  = 0;
    int unsigned words_seen  = 0;
    int unsigned mask_seen   = 0;
    int unsigned done_seen   = 0;

    // Words still owed by the block, oldest first
    t_word_rec pending_words[$];
    t_word_rec exp_w;
    t_word_rec got_w;

    // Decoder copy: registers
    int unsigned cfg_lw   = RST_LINE_WORDS;
    int unsigned cfg_rows = RST_ROW_COUNT;
    bit          cfg_mask = 1'b0;
    bit          cfg_pb   = 1'b1;

    // Decoder copy: state
    t_dec_phase  dec_phase    = PH_CMD;
    int unsigned lit_left     = 0;
    int unsigned run_left     = 0;
    bit          hi_pend      = 1'b0;
    logic [7:0]  hi_byte      = '0;
    int unsigned plane        = 0;
    int unsigned wip          = 0;
    int unsigned row          = 0;
    bit          img_finished = 1'b0;
    bit          row_overflow = 1'b0;

    function automatic int unsigned eff_line_words();
        if (cfg_lw == 0) return 1;
        if (cfg_lw > DEF_MAX_LINE_WORDS) return DEF_MAX_LINE_WORDS;
        return cfg_lw;
    endfunction

    function automatic int unsigned eff_rows();
        if (cfg_rows == 0) return 1;
        if (cfg_rows > DEF_MAX_ROWS) return DEF_MAX_ROWS;
        return cfg_rows;
    endfunction

    // Words still to place before the current row closes
    function automatic int unsigned words_left_in_row();
        int unsigned lw;
        int unsigned np;
        int unsigned cur;
        int unsigned after;
        lw    = eff_line_words();
        np    = cfg_mask ? PLANES_MASK : PLANES_BASE;
        cur   = (wip < lw) ? wip : lw - 1;
        after = (np > plane + 1) ? np - plane - 1 : 0;
        return after * lw + lw - cur;
    endfunction

    // Pair a data byte into a word and place it
    task automatic place_byte(input logic [7:0] b, inout int n);
        int unsigned lw;
        int unsigned planes;
        int unsigned addr;
        t_word_rec   w;
        if (img_finished || row_overflow) return;
        if (!hi_pend) begin
            hi_byte = b;
            hi_pend = 1'b1;
            return;
        end
        hi_pend = 1'b0;
        lw      = eff_line_words();
        planes  = cfg_mask ? PLANES_MASK : PLANES_BASE;
        w.data  = {hi_byte, b};
        w.mask  = (plane >= PLANES_BASE);
        w.done  = 1'b0;
        w.last  = 1'b0;
        if (w.mask)
            addr = row * lw + wip;
        else
            addr = row * PLANES_BASE * lw + plane + PLANES_BASE * wip;
        w.addr = ADDR_W'(addr);
        wip++;
        if (wip >= lw) begin
            wip = 0;
            plane++;
            if (plane >= planes) begin
                plane = 0;
                row++;
                if (cfg_pb) row_overflow = 1'b1;
                if (row >= eff_rows()) begin
                    img_finished = 1'b1;
                    w.done       = 1'b1;
                end
            end
        end
        pending_words.push_back(w);
        n++;
    endtask

    // Work out the words that one accepted byte causes
    task automatic decode_byte(input logic [7:0] b);
        int n;
        n = 0;
        if (img_finished) return;
        if (!cfg_pb) begin
            row_overflow = 1'b0;
            place_byte(b, n);
        end else begin
            case (dec_phase)
                PH_LITERAL: begin
                    place_byte(b, n);
                    if (lit_left > 0) lit_left--;
                    if (lit_left == 0) dec_phase = PH_CMD;
                end
                PH_RUN: begin
                    for (int unsigned i = 0; i < run_left; i++) place_byte(b, n);
                    run_left  = 0;
                    dec_phase = PH_CMD;
                end
                default: begin
                    row_overflow = 1'b0;
                    dec_phase    = PH_CMD;
                    if (b < CMD_NOP) begin
                        lit_left  = b + 1;
                        dec_phase = PH_LITERAL;
                    end else if (b != CMD_NOP) begin
                        run_left  = 257 - b;
                        dec_phase = PH_RUN;
                    end
                end
            endcase
        end
        if (n > 0) pending_words[pending_words.size() - 1].last = 1'b1;
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_LINE_WORDS: cfg_lw   = d[LINE_WORDS_W-1:0];
            REG_ROW_COUNT:  cfg_rows = d[ROW_COUNT_W-1:0];
            REG_HAS_MASK:   cfg_mask = d[0];
            REG_PACKBITS:   cfg_pb   = d[0];
            default: ;
        endcase
    endtask

    // Register write, enable high for one cycle, then cleared before the task returns
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        apply_reg(idx, CFG_DATA_W'(value));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // One byte transfer, with a random gap ahead of it
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_byte_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_byte_valid <= 1'b1;
        i_byte_in    <= b;
        do @(posedge i_clk); while (!o_byte_ready);
        decode_byte(b);
        bytes_sent++;
    endtask

    task automatic send_literal(input int unsigned count);
        send_byte(8'(count - 1));
        repeat (count) send_byte(8'($urandom_range(255)));
    endtask

    task automatic send_run(input int unsigned len, input logic [7:0] val);
        send_byte(8'(257 - len));
        send_byte(val);
    endtask

    // Sender stops and waits for every owed word
    task automatic drain_words();
        i_byte_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    // Idle point for a register write: owed words in, plus decode slack
    task automatic settle();
        drain_words();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Place an exact number of words through run commands, a lone byte through a literal (from a command boundary)
    task automatic feed_words(input int unsigned words);
        int unsigned nbytes;
        int unsigned k;
        nbytes = 2 * words - hi_pend;
        while (nbytes > 0) begin
            k = (nbytes > MAX_RUN_BYTES) ? MAX_RUN_BYTES : nbytes;
            if (k == 1)
                send_literal(1);
            else
                send_run(k, 8'($urandom_range(255)));
            nbytes -= k;
        end
    endtask

    // Finish whatever command a random stream left open
    task automatic complete_command();
        while (dec_phase != PH_CMD) send_byte(8'($urandom_range(255)));
    endtask

    // Mostly well-formed PackBits commands, some stray bytes
    task automatic run_random_traffic(input int unsigned count);
        int unsigned start;
        int unsigned r;
        int unsigned len;
        start = bytes_sent;
        while (bytes_sent - start < count) begin
            r = $urandom_range(99);
            if (r < 55) begin
                len = ($urandom_range(7) == 0) ? $urandom_range(40, 16) : $urandom_range(6, 1);
                send_literal(len);
            end else if (r < 85) begin
                len = ($urandom_range(3) == 0) ? MAX_RUN_BYTES : $urandom_range(MAX_RUN_BYTES, 2);
                send_run(len, 8'($urandom_range(255)));
            end else if (r < 90) begin
                send_byte(CMD_NOP);
            end else begin
                send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic run_raw_traffic(input int unsigned count);
        repeat (count) send_byte(8'($urandom_range(255)));
    endtask

    // ---------------- tests ----------------

    // Literal commands at reset settings, byte extremes, a word split across commands
    task automatic test_literal_commands();
        send_byte(8'(4 - 1));
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(CMD_NOP);
        send_byte(8'(1 - 1));
        send_byte(8'h12);
        send_byte(8'(1 - 1));
        send_byte(8'h34);
    endtask

    // Shortest and longest runs
    task automatic test_run_commands();
        send_run(2, 8'hA5);
        send_run(MAX_RUN_BYTES, 8'h5A);
    endtask

    // Out-of-range sizes saturate; a zero line length is taken as one word
    task automatic test_line_words_limits();
        settle();
        write_reg(REG_LINE_WORDS, 127);
        write_reg(REG_ROW_COUNT, 2047);
        send_run(MAX_RUN_BYTES, 8'hC3);
        settle();
        write_reg(REG_LINE_WORDS, 0);
        send_run(4, 8'h3C);
    endtask

    // Data past the row end is dropped; raw mode cancels that and keeps the command state
    task automatic test_row_overflow();
        settle();
        write_reg(REG_LINE_WORDS, 2);
        if (words_left_in_row() > 1) feed_words(words_left_in_row() - 1);
        send_byte(8'(6 - 1));
        repeat (3) send_byte(8'($urandom_range(255)));
        settle();
        write_reg(REG_PACKBITS, 0);
        repeat (2) send_byte(8'($urandom_range(255)));
        settle();
        write_reg(REG_PACKBITS, 1);
        repeat (3) send_byte(8'($urandom_range(255)));
        if (words_left_in_row() > 1) feed_words(words_left_in_row() - 1);
        send_run(MAX_RUN_BYTES, 8'hE7);
    endtask

    // Mask plane words; a mask plane already begun finishes after the flag is cleared
    task automatic test_mask_plane();
        settle();
        write_reg(REG_HAS_MASK, 1);
        feed_words(words_left_in_row() - eff_line_words() + 1);
        settle();
        write_reg(REG_HAS_MASK, 0);
        send_literal(2);
    endtask

    // Random commands, sender idles less than receiver
    task automatic test_random_sparse();
        settle();
        write_reg(REG_LINE_WORDS, 3);
        run_random_traffic(32);
    endtask

    // Random commands with the mask plane, a long receiver stall and a sender pause
    task automatic test_random_backpressure();
        settle();
        tx_idle_pct = 48;
        rx_idle_pct = 37;
        write_reg(REG_LINE_WORDS, 6);
        write_reg(REG_HAS_MASK, 1);
        run_random_traffic(10);
        complete_command();
        hold_cycles = HOLD_OFF;
        repeat (5) send_run(MAX_RUN_BYTES, 8'($urandom_range(255)));
        run_random_traffic(10);
        drain_words();
        run_random_traffic(10);
    endtask

    // No idling: a raw stretch, then PackBits again
    task automatic test_random_mixed();
        settle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(REG_LINE_WORDS, 1);
        write_reg(REG_PACKBITS, 0);
        run_raw_traffic(20);
        settle();
        write_reg(REG_LINE_WORDS, 2);
        write_reg(REG_ROW_COUNT, 1024);
        write_reg(REG_PACKBITS, 1);
        run_random_traffic(20);
    endtask

    // Close the image on the current row, then bytes that must be ignored
    task automatic test_final_row();
        settle();
        complete_command();
        settle();
        write_reg(REG_ROW_COUNT, 0);
        feed_words(words_left_in_row());
        repeat (4) send_byte(8'($urandom_range(255)));
        settle();
    endtask

    // ---------------- receiver and checker ----------------

    // Receiver: long hold-off when asked, random stalls otherwise
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_word_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            i_word_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic report_word(input string what, input t_word_rec e, input t_word_rec g);
        err_count++;
        if (err_count <= 10) begin
            $display("%s: expected addr=%05h mask=%0b data=%04h done=%0b last=%0b",
                     what, e.addr, e.mask, e.data, e.done, e.last);
            $display("    got      addr=%05h mask=%0b data=%04h done=%0b last=%0b",
                     g.addr, g.mask, g.data, g.done, g.last);
        end
    endtask

    // Each word transfer against the oldest owed word
    always @(posedge i_clk) begin
        if (i_rst_n && o_word_valid && i_word_ready) begin
            got_w = '{o_word_addr, o_is_mask, o_word_data, o_image_done, o_last};
            words_seen++;
            if (o_is_mask) mask_seen++;
            if (o_image_done) done_seen++;
            if (pending_words.size() == 0) begin
                report_word("word with none owed", '0, got_w);
            end else begin
                exp_w = pending_words.pop_front();
                if (got_w.addr !== exp_w.addr || got_w.mask !== exp_w.mask ||
                    got_w.data !== exp_w.data || got_w.done !== exp_w.done ||
                    got_w.last !== exp_w.last)
                    report_word("word differs", exp_w, got_w);
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_literal_commands();
        test_run_commands();
        test_line_words_limits();
        test_row_overflow();
        test_mask_plane();
        test_random_sparse();
        test_random_backpressure();
        test_random_mixed();
        test_final_row();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d body bytes in raw and PackBits modes; checked %0d words, %0d mask",
                 bytes_sent, words_seen, mask_seen);
        $display("Line and row limits, row overflow, mode switches and image end seen %0d time(s)",
                 done_seen);
        if (err_count == 0)
            $display("packbits_bitplane_interleaver: match");
        else
            $display("packbits_bitplane_interleaver: mismatch");
        $finish;
    end

    // Overall time limit
    initial begin
        #2000000;
        $display("packbits_bitplane_interleaver: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/pbi_pkg.sv
hw/rtl/pbi_ctrl.sv
hw/rtl/pbi_datapath.sv
hw/rtl/packbits_bitplane_interleaver.sv
tb/packbits_bitplane_interleaver_tb.sv
